@@ sv/wgm_pkg.sv @@
package wgm_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int CHAR_BITS_DEF   = 16;

  localparam int ACT_W  = 2;
  localparam int DATA_W = 16;
  localparam int OUT_W  = 8;

  localparam int STAR_CODE  = 42;
  localparam int QMARK_CODE = 63;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_SOURCE = 2'd1,
    ACT_END    = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef struct packed {
    logic append;
    logic clear;
  } store_cmd_t;

endpackage

@@ sv/wgm_store.sv @@
module wgm_store #(
  parameter int MAX_PATTERN = 32,
  parameter int CHAR_BITS   = 16,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wgm_pkg::store_cmd_t     cmd_i,
  input  logic [CHAR_BITS-1:0]    char_i,
  output logic [MAX_PATTERN:0]    star_o,
  output logic [MAX_PATTERN:0]    hit_o,
  output logic [LEN_W-1:0]        len_o,
  output logic                    ovf_o
);
  import wgm_pkg::*;

  localparam logic [CHAR_BITS-1:0] STAR  = CHAR_BITS'(STAR_CODE);
  localparam logic [CHAR_BITS-1:0] QMARK = CHAR_BITS'(QMARK_CODE);

  logic [CHAR_BITS-1:0] pat_q [MAX_PATTERN];
  logic [LEN_W-1:0]     len_q;
  logic                 ovf_q;

  // pattern characters, written at the current length
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (cmd_i.append && len_q == LEN_W'(i)) begin
        pat_q[i] <= char_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.clear) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.append) begin
      if (len_q < LEN_W'(MAX_PATTERN)) begin
        len_q <= len_q + LEN_W'(1);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // per-position decode against the current source character
  always_comb begin
    star_o = '0;
    hit_o  = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      star_o[i] = (LEN_W'(i) < len_q) && (pat_q[i] == STAR);
      hit_o[i]  = (LEN_W'(i) < len_q) && (pat_q[i] != STAR) &&
                  ((pat_q[i] == QMARK) || (pat_q[i] == char_i));
    end
  end

  assign len_o = len_q;
  assign ovf_o = ovf_q;

endmodule

@@ sv/wgm_step.sv @@
module wgm_step #(
  parameter int MAX_PATTERN = 32,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic [MAX_PATTERN:0] act_i,
  input  logic [MAX_PATTERN:0] star_i,
  input  logic [MAX_PATTERN:0] hit_i,
  input  logic [LEN_W-1:0]     len_i,
  output logic [MAX_PATTERN:0] next_o,
  output logic                 verdict_o
);
  import wgm_pkg::*;

  localparam int POS = MAX_PATTERN + 1;

  logic [POS-1:0] gen;
  logic [POS-1:0] sum;
  logic [POS-1:0] carry;
  logic [POS-1:0] cur;

  // star closure as a carry chain: stars propagate, active stars generate
  assign gen   = star_i & act_i;
  assign sum   = star_i + gen;
  assign carry = sum ^ star_i ^ gen;
  assign cur   = act_i | carry;

  assign next_o    = (cur & star_i) | {cur[POS-2:0] & hit_i[POS-2:0], 1'b0};
  assign verdict_o = cur[len_i];

endmodule

@@ sv/wildcard_glob_matcher.sv @@
// a verdict is offered from the result register, after its end-of-source item has passed the input register
// throughput: one item per cycle unless stalled; set by the combinational star closure carry chain
// the input side stalls only while a verdict waits and the next item is also a verdict
// reset: pattern emptied, overflow flag cleared, only the start position active
// pattern characters reset to unknown and are never read before being written
module wildcard_glob_matcher #(
  parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
  parameter int CHAR_BITS   = wgm_pkg::CHAR_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [wgm_pkg::DATA_W-1:0]   s_axis_tdata_i,  // char_value
  input  logic [wgm_pkg::ACT_W-1:0]    s_axis_tuser_i,  // action
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [wgm_pkg::OUT_W-1:0]    m_axis_tdata_o   // matched, pattern_overflow
);
  import wgm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic                   s1_valid_q;
  action_e                s1_act_q;
  logic [CHAR_BITS-1:0]   s1_char_q;
  logic [31:0]            char_wide;
  logic                   s1_advance;
  logic                   end_fire;
  store_cmd_t             cmd;

  logic [MAX_PATTERN:0]   active_q;
  logic [MAX_PATTERN:0]   star;
  logic [MAX_PATTERN:0]   hit;
  logic [MAX_PATTERN:0]   next_act;
  logic [LEN_W-1:0]       len;
  logic                   ovf;
  logic                   verdict;

  logic                   out_valid_q;
  logic                   matched_q;
  logic                   ovf_out_q;

  assign char_wide = 32'(s_axis_tdata_i);

  assign s1_advance = s1_valid_q &&
                      (s1_act_q != ACT_END || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_advance;
  assign end_fire = s1_advance && s1_act_q == ACT_END;

  assign cmd.append = s1_advance && s1_act_q == ACT_APPEND;
  assign cmd.clear  = s1_advance && s1_act_q == ACT_CLEAR;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_act_q  <= action_e'(s_axis_tuser_i);
      s1_char_q <= char_wide[CHAR_BITS-1:0];
    end
  end

  wgm_store #(
    .MAX_PATTERN (MAX_PATTERN),
    .CHAR_BITS   (CHAR_BITS),
    .LEN_W       (LEN_W)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .char_i (s1_char_q),
    .star_o (star),
    .hit_o  (hit),
    .len_o  (len),
    .ovf_o  (ovf)
  );

  wgm_step #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_step (
    .act_i     (active_q),
    .star_i    (star),
    .hit_i     (hit),
    .len_i     (len),
    .next_o    (next_act),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= (MAX_PATTERN + 1)'(1);
    end else if (s1_advance) begin
      case (s1_act_q)
        ACT_SOURCE: active_q <= next_act;
        ACT_END:    active_q <= (MAX_PATTERN + 1)'(1);
        ACT_CLEAR:  active_q <= (MAX_PATTERN + 1)'(1);
        default:    active_q <= active_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (end_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_fire) begin
      matched_q <= verdict;
      ovf_out_q <= ovf;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_W - 2){1'b0}}, ovf_out_q, matched_q};

  // clear empties the pattern and rearms
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |=> (len == '0) && !ovf && (active_q == (MAX_PATTERN + 1)'(1)))
    else $error("clear did not empty the pattern");

  // no active position lies beyond the pattern end
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((active_q >> len) >> 1) == '0)
    else $error("active position beyond pattern length");

  // a verdict always lands in the result register and rearms
  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_fire |=> out_valid_q && (active_q == (MAX_PATTERN + 1)'(1)))
    else $error("verdict lost or matcher not rearmed");

  // input stalls only behind a waiting verdict
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> out_valid_q && !m_axis_tready_i && s1_act_q == ACT_END)
    else $error("input stalled without cause");

endmodule

@@ sim/glob_verdict_checker.sv @@
`timescale 1ns / 1ps

module glob_verdict_checker #(
  parameter int MAXP = wgm_pkg::MAX_PATTERN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  input  logic                       s_tready_i,
  input  logic [wgm_pkg::DATA_W-1:0] s_tdata_i,
  input  logic [wgm_pkg::ACT_W-1:0]  s_tuser_i,
  input  logic                       m_tvalid_i,
  input  logic                       m_tready_i,
  input  logic [wgm_pkg::OUT_W-1:0]  m_tdata_i,
  output int                         errors_o,
  output int                         open_o,
  output int                         verdicts_o,
  output int                         hits_o,
  output int                         flagged_o
);
  import wgm_pkg::*;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  verdict_t          verdict_q[$];
  logic [DATA_W-1:0] pat [MAXP];
  int                pat_len = 0;
  logic [MAXP:0]     live = (MAXP + 1)'(1);
  logic              ovf = 1'b0;
  int                errors = 0;
  int                verdicts = 0;
  int                hits = 0;
  int                flagged = 0;

  // live positions plus everything reachable across stars
  function automatic logic [MAXP:0] star_reach();
    logic [MAXP:0] r;
    r = live;
    for (int i = 0; i < pat_len; i++) begin
      if (r[i] && pat[i] == STAR_CODE) r[i+1] = 1'b1;
    end
    return r;
  endfunction

  task automatic rearm();
    live    = '0;
    live[0] = 1'b1;
  endtask

  task automatic take_item(input action_e act, input logic [DATA_W-1:0] ch);
    logic [MAXP:0] reach;
    logic [MAXP:0] nxt;
    case (act)
      ACT_APPEND: begin
        if (pat_len < MAXP) begin
          pat[pat_len] = ch;
          pat_len++;
        end else begin
          ovf = 1'b1;
        end
      end
      ACT_SOURCE: begin
        reach = star_reach();
        nxt   = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (reach[i]) begin
            if (pat[i] == STAR_CODE) nxt[i] = 1'b1;
            else if (pat[i] == QMARK_CODE || pat[i] == ch) nxt[i+1] = 1'b1;
          end
        end
        live = nxt;
      end
      ACT_END: begin
        reach = star_reach();
        verdict_q.push_back('{matched: reach[pat_len], overflow: ovf});
        rearm();
      end
      default: begin
        pat_len = 0;
        ovf     = 1'b0;
        rearm();
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t seen;
    verdict_t want;
    if (!rst_ni) begin
      pat_len = 0;
      ovf     = 1'b0;
      rearm();
      verdict_q.delete();
    end else begin
      // results first: a verdict leaving now never belongs to an item taken now
      if (m_tvalid_i === 1'b1 && m_tready_i === 1'b1) begin
        seen = '{matched: m_tdata_i[0], overflow: m_tdata_i[1]};
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected verdict transfer, expected none, got %b", $time, m_tdata_i);
        end else begin
          want = verdict_q.pop_front();
          verdicts++;
          hits    += int'(want.matched);
          flagged += int'(want.overflow);
          if (seen.matched !== want.matched) begin
            errors++;
            $display("%0t: matched mismatch, expected %b, got %b", $time,
                     want.matched, seen.matched);
          end
          if (seen.overflow !== want.overflow) begin
            errors++;
            $display("%0t: pattern_overflow mismatch, expected %b, got %b", $time,
                     want.overflow, seen.overflow);
          end
        end
      end
      if (s_tvalid_i === 1'b1 && s_tready_i === 1'b1) begin
        take_item(action_e'(s_tuser_i), s_tdata_i);
      end
    end
    errors_o   <= errors;
    open_o     <= verdict_q.size();
    verdicts_o <= verdicts;
    hits_o     <= hits;
    flagged_o  <= flagged;
  end

endmodule

@@ sim/tb_wildcard_glob_matcher.sv @@
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher;
  import wgm_pkg::*;

  localparam int ITEM_GOAL   = 1850;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 240;
  localparam int MAXP        = MAX_PATTERN_DEF;

  localparam logic [DATA_W-1:0] STAR_CH  = DATA_W'(STAR_CODE);
  localparam logic [DATA_W-1:0] QMARK_CH = DATA_W'(QMARK_CODE);

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic [ACT_W-1:0]  s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  logic calm = 1'b0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;
  int   items = 0;
  int   cycles = 0;
  int   errors;
  int   open;
  int   verdicts;
  int   hits;
  int   flagged;

  always #6 clk_i = ~clk_i;

  wildcard_glob_matcher DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  glob_verdict_checker #(.MAXP(MAXP)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (errors),
    .open_o     (open),
    .verdicts_o (verdicts),
    .hits_o     (hits),
    .flagged_o  (flagged)
  );

  // receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input action_e act, input logic [DATA_W-1:0] ch);
    while (!calm && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    items++;
  endtask

  // sender quiet until every verdict has been seen
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (open != 0);
  endtask

  function automatic logic [DATA_W-1:0] text_char();
    logic [DATA_W-1:0] c;
    if ($urandom_range(7) == 0) c = DATA_W'($urandom);
    else c = DATA_W'(32'h61 + $urandom_range(2));
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] pattern_char();
    int r;
    r = $urandom_range(9);
    if (r < 3) return STAR_CH;
    if (r < 5) return QMARK_CH;
    return text_char();
  endfunction

  // clear, load a pattern, then match a few strings built mostly to fit it
  task automatic run_session(input bit overfill);
    logic [DATA_W-1:0] pat_q[$];
    logic [DATA_W-1:0] src_q[$];
    logic [DATA_W-1:0] c;
    int                plen;
    int                r;
    int                mode;
    int                cut;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 4)) send_item(action_e'($urandom_range(3)), DATA_W'($urandom));
    end
    send_item(ACT_CLEAR, DATA_W'($urandom));
    r = $urandom_range(19);
    if (overfill || r == 19) plen = $urandom_range(MAXP, MAXP + 6);
    else if (r < 14) plen = $urandom_range(0, 6);
    else plen = $urandom_range(7, MAXP - 1);
    repeat (plen) begin
      c = pattern_char();
      send_item(ACT_APPEND, c);
      if (pat_q.size() < MAXP) pat_q.push_back(c);
    end
    repeat ($urandom_range(1, 5)) begin
      src_q.delete();
      foreach (pat_q[i]) begin
        if (pat_q[i] == STAR_CH) repeat ($urandom_range(0, 3)) src_q.push_back(text_char());
        else if (pat_q[i] == QMARK_CH) src_q.push_back(text_char());
        else src_q.push_back(pat_q[i]);
      end
      mode = $urandom_range(9);
      if (mode == 6 && src_q.size() > 0) begin
        src_q[$urandom_range(src_q.size() - 1)] = text_char();
      end else if (mode == 7 && src_q.size() > 0) begin
        src_q.delete($urandom_range(src_q.size() - 1));
      end else if (mode == 8) begin
        src_q.push_front(text_char());
      end else if (mode == 9) begin
        src_q.delete();
        repeat ($urandom_range(0, 8)) src_q.push_back(text_char());
      end
      cut = -1;
      if (src_q.size() > 0 && $urandom_range(11) == 0) cut = $urandom_range(src_q.size() - 1);
      foreach (src_q[i]) begin
        if (i == cut) begin
          c = pattern_char();
          send_item(ACT_APPEND, c);
          if (pat_q.size() < MAXP) pat_q.push_back(c);
        end
        send_item(ACT_SOURCE, src_q[i]);
      end
      send_item(ACT_END, DATA_W'($urandom));
    end
  endtask

  initial begin
    int sessions;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern against empty and non-empty strings
    send_item(ACT_END, 16'h0000);
    send_item(ACT_SOURCE, 16'h0000);
    send_item(ACT_END, 16'hFFFF);
    // code zero and all-ones as plain characters
    send_item(ACT_APPEND, 16'h0000);
    send_item(ACT_APPEND, 16'hFFFF);
    send_item(ACT_SOURCE, 16'h0000);
    send_item(ACT_SOURCE, 16'hFFFF);
    send_item(ACT_END, 16'h5555);
    send_item(ACT_CLEAR, 16'hFFFF);
    // star, question mark and a literal, with case sensitivity
    send_item(ACT_APPEND, STAR_CH);
    send_item(ACT_APPEND, QMARK_CH);
    send_item(ACT_APPEND, 16'h0061);
    send_item(ACT_SOURCE, 16'h0041);
    send_item(ACT_SOURCE, 16'h0061);
    send_item(ACT_END, 16'hAAAA);
    send_item(ACT_SOURCE, 16'h0061);
    send_item(ACT_END, 16'h0000);
    send_item(ACT_SOURCE, 16'h0062);
    send_item(ACT_SOURCE, 16'h0041);
    send_item(ACT_END, 16'h0000);
    // pattern grows in the middle of a string
    send_item(ACT_SOURCE, 16'h0062);
    send_item(ACT_APPEND, STAR_CH);
    send_item(ACT_SOURCE, 16'h0061);
    send_item(ACT_END, 16'h0000);
    send_item(ACT_CLEAR, 16'h0000);
    send_item(ACT_END, 16'hFFFF);
    drain();

    sessions = 0;
    while (items < ITEM_GOAL) begin
      if (sessions == 25) calm <= 1'b1;
      if (sessions == 45) calm <= 1'b0;
      if (sessions == 60) begin
        // receiver blocked while a burst of verdicts queues up
        hold_req <= hold_req + 1;
        repeat (12) send_item(ACT_END, DATA_W'($urandom));
      end
      run_session(sessions == 0);
      if (sessions % 20 == 19) drain();
      sessions++;
    end
    drain();
    repeat (10) @(posedge clk_i);

    $display("%0d transfers in %0d pattern sessions, %0d verdicts checked", items, sessions,
             verdicts);
    $display("%0d verdicts matched, %0d reported a dropped pattern character", hits, flagged);
    if (errors == 0 && open == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
